FILE: rtl/bcs_pkg.sv
// shared types and constants of the boustrophedon coverage step
// no dependencies
package bcs_pkg;

  localparam int GRID_SIDE_DEF    = 128;
  localparam int ORIGIN_INDEX_DEF = 64;
  localparam int COORD_W          = 7;
  localparam int COORD_CAP        = 128;
  localparam int SCAN_CW          = 8;
  localparam int DIST_W           = 15;

  typedef enum logic [1:0] {
    TILE_UNKNOWN = 2'd0,
    TILE_FREE    = 2'd1,
    TILE_COVERED = 2'd2,
    TILE_BLOCKED = 2'd3
  } tile_t;

  typedef enum logic [1:0] {
    STAT_KEPT      = 2'd0,
    STAT_NEW_DIR   = 2'd1,
    STAT_BACKTRACK = 2'd2,
    STAT_CRITICAL  = 2'd3
  } status_t;

  typedef struct packed {
    logic               valid;
    tile_t              tile;
    logic [SCAN_CW-1:0] row;
    logic [SCAN_CW-1:0] col;
  } scan_push_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } scan_best_t;

endpackage

FILE: rtl/bcs_in_if.sv
// input channel of the coverage step: robot tile and neighbor free flags
// depends on bcs_pkg
interface bcs_in_if;
  logic                        valid;
  logic                        ready;
  logic [bcs_pkg::COORD_W-1:0] robot_row;
  logic [bcs_pkg::COORD_W-1:0] robot_col;
  logic                        free_north;
  logic                        free_south;
  logic                        free_east;
  logic                        free_west;

  modport source (output valid, robot_row, robot_col, free_north, free_south,
                  free_east, free_west, input ready);
  modport sink (input valid, robot_row, robot_col, free_north, free_south,
                free_east, free_west, output ready);
endinterface

FILE: rtl/bcs_out_if.sv
// output channel of the coverage step: goal tile and step status
// depends on bcs_pkg
interface bcs_out_if;
  logic                        valid;
  logic                        ready;
  logic [bcs_pkg::COORD_W-1:0] goal_row;
  logic [bcs_pkg::COORD_W-1:0] goal_col;
  logic [1:0]                  step_status;

  modport source (output valid, goal_row, goal_col, step_status, input ready);
  modport sink (input valid, goal_row, goal_col, step_status, output ready);
endinterface

FILE: rtl/bcs_scan.sv
// backtracking point search: 3x3 window over the streamed map, nearest pick
// depends on bcs_pkg
module bcs_scan #(
  parameter int ROW_W     = 128,
  parameter int SCAN_LAST = 126
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  bcs_pkg::scan_push_t         push,
  input  logic [bcs_pkg::COORD_W-1:0] robot_row,
  input  logic [bcs_pkg::COORD_W-1:0] robot_col,
  output bcs_pkg::scan_best_t         best
);

  localparam int SL_LEN = 2 * ROW_W + 3;
  localparam logic [bcs_pkg::SCAN_CW-1:0] LO = bcs_pkg::SCAN_CW'(2);
  localparam logic [bcs_pkg::SCAN_CW-1:0] HI = bcs_pkg::SCAN_CW'(SCAN_LAST + 1);

  bcs_pkg::tile_t               sl [SL_LEN];
  logic                         wv;
  logic [bcs_pkg::SCAN_CW-1:0]  wr, wc;

  logic                         cv;
  logic [bcs_pkg::COORD_W-1:0]  ci, cj;
  logic [bcs_pkg::DIST_W-1:0]   cd;

  logic                         found;
  logic [bcs_pkg::COORD_W-1:0]  bi, bj;
  logic [bcs_pkg::DIST_W-1:0]   bd;

  logic                         is_cand;
  logic [bcs_pkg::COORD_W-1:0]  ii, jj, dr, dc;
  logic                         de, dw, ds;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      sl[0] <= push.tile;
      for (int k = 1; k < SL_LEN; k++) begin
        sl[k] <= sl[k-1];
      end
      wr <= push.row;
      wc <= push.col;
    end
  end

  function automatic logic hard(bcs_pkg::tile_t t);
    return (t == bcs_pkg::TILE_COVERED) || (t == bcs_pkg::TILE_BLOCKED);
  endfunction

  always_comb begin
    ii = bcs_pkg::COORD_W'(wr - 8'd1);
    jj = bcs_pkg::COORD_W'(wc - 8'd1);
    de = (sl[ROW_W+2] == bcs_pkg::TILE_FREE) && (hard(sl[2]) || hard(sl[2*ROW_W+2]));
    dw = (sl[ROW_W] == bcs_pkg::TILE_FREE) && (hard(sl[0]) || hard(sl[2*ROW_W]));
    ds = (sl[2*ROW_W+1] == bcs_pkg::TILE_FREE) &&
         (hard(sl[2*ROW_W]) || hard(sl[2*ROW_W+2]));
    is_cand = wv && wr >= LO && wr <= HI && wc >= LO && wc <= HI &&
              sl[ROW_W+1] == bcs_pkg::TILE_COVERED && (de || dw || ds);
    dr = (ii >= robot_row) ? ii - robot_row : robot_row - ii;
    dc = (jj >= robot_col) ? jj - robot_col : robot_col - jj;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wv    <= 1'b0;
      cv    <= 1'b0;
      found <= 1'b0;
    end else begin
      wv <= push.valid;
      cv <= is_cand;
      if (cv && (!found || cd < bd)) begin
        found <= 1'b1;
      end
    end
    ci <= ii;
    cj <= jj;
    cd <= bcs_pkg::DIST_W'(dr) * bcs_pkg::DIST_W'(dr) +
          bcs_pkg::DIST_W'(dc) * bcs_pkg::DIST_W'(dc);
    if (cv && (!found || cd < bd)) begin
      bd <= cd;
      bi <= ci;
      bj <= cj;
    end
  end

  assign best = '{found: found, row: bi, col: bj};

endmodule

FILE: rtl/boustrophedon_coverage_step.sv
// Boustrophedon coverage step. After reset the tile map memory is cleared one
// tile a cycle (all GRID_SIDE*GRID_SIDE tiles, capped at 128*128) before
// the first beat is taken. An ordinary step passes through a covered write
// when the robot stands on its goal, a read then decide pass for each of the
// four neighbors on the single map memory, the output register load and a
// return to idle. A critical point adds a streaming pass that reads every
// tile once through a 3x3 window over min(GRID_SIDE,129) rows and columns,
// then a pipeline drain. One step is worked at a time; a finished result
// waits in the output register.
// depends on bcs_pkg, bcs_in_if, bcs_out_if, bcs_scan
module boustrophedon_coverage_step #(
  parameter int GRID_SIDE    = bcs_pkg::GRID_SIDE_DEF,
  parameter int ORIGIN_INDEX = bcs_pkg::ORIGIN_INDEX_DEF
) (
  input logic      clk,
  input logic      rst,
  bcs_in_if.sink   step_in,
  bcs_out_if.source step_out
);

  localparam int EFF_SIDE  = (GRID_SIDE < bcs_pkg::COORD_CAP) ? GRID_SIDE : bcs_pkg::COORD_CAP;
  localparam int SCAN_LAST = (GRID_SIDE - 2 < 127) ? GRID_SIDE - 2 : 127;
  localparam int ROW_W     = SCAN_LAST + 2;
  localparam int MAP_DEPTH = EFF_SIDE * EFF_SIDE;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int CW        = bcs_pkg::COORD_W;
  localparam int SW        = bcs_pkg::SCAN_CW;
  localparam logic [CW-1:0]     ORIGIN   = CW'(ORIGIN_INDEX % bcs_pkg::COORD_CAP);
  localparam logic [SW-1:0]     EFF_S    = SW'(EFF_SIDE);
  localparam logic [SW-1:0]     SCAN_END = SW'(ROW_W - 1);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(MAP_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_COVER, S_NREAD, S_NDEC, S_SCAN, S_DRAIN, S_DONE
  } state_t;

  state_t state;

  bcs_pkg::tile_t mem [MAP_DEPTH];
  bcs_pkg::tile_t rdata;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  bcs_pkg::tile_t    wdata;

  logic [CW-1:0]     rr, rc, goal_row, goal_col;
  logic [3:0]        freef;
  logic              has_goal, chosen;
  logic [1:0]        k;
  logic [ADDR_W-1:0] clr_addr;
  logic [SW-1:0]     sr, sc;
  logic [2:0]        drain;
  bcs_pkg::status_t  status;

  logic              p_valid, p_inmap;
  logic [SW-1:0]     p_row, p_col;
  bcs_pkg::scan_push_t push;
  bcs_pkg::scan_best_t best;
  logic              scan_clear;

  logic [SW-1:0]     nr, nc;
  logic              n_in, n_free, robot_in, take;

  function automatic logic [ADDR_W-1:0] addr_of(logic [SW-1:0] r, logic [SW-1:0] c);
    return ADDR_W'(32'(r) * EFF_SIDE + 32'(c));
  endfunction

  always_comb begin
    nr = {1'b0, rr};
    nc = {1'b0, rc};
    n_in = 1'b1;
    case (k)
      2'd0: nr = {1'b0, rr} + 8'd1;
      2'd1: begin
        nr = {1'b0, rr} - 8'd1;
        n_in = (rr != '0);
      end
      2'd2: begin
        nc = {1'b0, rc} - 8'd1;
        n_in = (rc != '0);
      end
      default: nc = {1'b0, rc} + 8'd1;
    endcase
    n_in = n_in && nr < EFF_S && nc < EFF_S;
    n_free = freef[k];
    robot_in = {1'b0, rr} < EFF_S && {1'b0, rc} < EFF_S;
    take = !(n_in && rdata == bcs_pkg::TILE_COVERED) && n_in && n_free && !has_goal;
  end

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    waddr = addr_of(nr, nc);
    raddr = addr_of(nr, nc);
    wdata = bcs_pkg::TILE_UNKNOWN;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_addr;
      end
      S_COVER: begin
        we = (goal_row == rr) && (goal_col == rc) && robot_in;
        waddr = addr_of({1'b0, rr}, {1'b0, rc});
        wdata = bcs_pkg::TILE_COVERED;
      end
      S_NREAD: re = n_in;
      S_NDEC: begin
        if (n_in && rdata != bcs_pkg::TILE_COVERED) begin
          if (!n_free) begin
            we = 1'b1;
            wdata = bcs_pkg::TILE_BLOCKED;
          end else if (has_goal) begin
            we = 1'b1;
            wdata = bcs_pkg::TILE_FREE;
          end
        end
      end
      S_SCAN: begin
        re = sr < EFF_S && sc < EFF_S;
        raddr = addr_of(sr, sc);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= (state == S_SCAN);
    end
    p_row   <= sr;
    p_col   <= sc;
    p_inmap <= sr < EFF_S && sc < EFF_S;
  end

  assign push = '{valid: p_valid,
                  tile: p_inmap ? rdata : bcs_pkg::TILE_UNKNOWN,
                  row: p_row, col: p_col};
  assign scan_clear = (state == S_NDEC);

  bcs_scan #(.ROW_W(ROW_W), .SCAN_LAST(SCAN_LAST)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clear     (scan_clear),
    .push      (push),
    .robot_row (rr),
    .robot_col (rc),
    .best      (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      goal_row <= ORIGIN;
      goal_col <= ORIGIN;
      has_goal <= 1'b0;
      step_out.valid <= 1'b0;
    end else begin
      if (step_out.valid && step_out.ready && state != S_DONE) begin
        step_out.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (step_in.valid) begin
            rr    <= step_in.robot_row;
            rc    <= step_in.robot_col;
            freef <= {step_in.free_west, step_in.free_east,
                      step_in.free_south, step_in.free_north};
            state <= S_COVER;
          end
        end
        S_COVER: begin
          if (goal_row == rr && goal_col == rc) begin
            has_goal <= 1'b0;
          end
          k      <= 2'd0;
          chosen <= 1'b0;
          state  <= S_NREAD;
        end
        S_NREAD: state <= S_NDEC;
        S_NDEC: begin
          if (take) begin
            goal_row <= CW'(nr);
            goal_col <= CW'(nc);
            has_goal <= 1'b1;
            chosen   <= 1'b1;
          end
          if (k != 2'd3) begin
            k     <= k + 2'd1;
            state <= S_NREAD;
          end else if (chosen || take) begin
            status <= bcs_pkg::STAT_NEW_DIR;
            state  <= S_DONE;
          end else if (!has_goal) begin
            sr    <= '0;
            sc    <= '0;
            state <= S_SCAN;
          end else begin
            status <= bcs_pkg::STAT_KEPT;
            state  <= S_DONE;
          end
        end
        S_SCAN: begin
          if (sc == SCAN_END) begin
            sc <= '0;
            sr <= sr + SW'(1);
            if (sr == SCAN_END) begin
              drain <= '0;
              state <= S_DRAIN;
            end
          end else begin
            sc <= sc + SW'(1);
          end
        end
        S_DRAIN: begin
          drain <= drain + 3'd1;
          if (drain == 3'd5) begin
            has_goal <= 1'b1;
            if (best.found) begin
              goal_row <= best.row;
              goal_col <= best.col;
              status   <= bcs_pkg::STAT_BACKTRACK;
            end else begin
              status <= bcs_pkg::STAT_CRITICAL;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!step_out.valid || step_out.ready) begin
            step_out.valid       <= 1'b1;
            step_out.goal_row    <= goal_row;
            step_out.goal_col    <= goal_col;
            step_out.step_status <= status;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign step_in.ready = (state == S_IDLE);

endmodule

FILE: sim/boustrophedon_coverage_step_tb.sv
// self-checking testbench of the boustrophedon coverage step: a scoreboard
// class predicts goal and status per beat, tasks drive the input channel and a process the output ready
// depends on bcs_pkg, bcs_in_if, bcs_out_if and boustrophedon_coverage_step
module boustrophedon_coverage_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE      = 128;
  localparam int ORIGIN    = 64;
  localparam int NUM_RAND  = 100;
  localparam int WDOG_MAX  = 200000;

  typedef struct {
    logic [6:0]       row;
    logic [6:0]       col;
    bcs_pkg::status_t status;
  } goal_t;

  class coverage_scoreboard;
    bcs_pkg::tile_t grid [SIDE][SIDE];
    logic [6:0] goal_r;
    logic [6:0] goal_c;
    bit         has_goal;
    goal_t      pending [$];
    int         errors;
    int         stat_cnt [4];

    function new();
      foreach (grid[i, j]) grid[i][j] = bcs_pkg::TILE_UNKNOWN;
      goal_r = 7'(ORIGIN);
      goal_c = 7'(ORIGIN);
      has_goal = 0;
      errors = 0;
      foreach (stat_cnt[i]) stat_cnt[i] = 0;
    endfunction

    function bit on_grid(int r, int c);
      return r >= 0 && c >= 0 && r < SIDE && c < SIDE;
    endfunction

    function bcs_pkg::tile_t tile_at(int r, int c);
      if (!on_grid(r, c)) return bcs_pkg::TILE_UNKNOWN;
      return grid[r][c];
    endfunction

    function void mark(int r, int c, bcs_pkg::tile_t v);
      if (on_grid(r, c)) grid[r][c] = v;
    endfunction

    function bit closed(int r, int c);
      return tile_at(r, c) inside {bcs_pkg::TILE_COVERED, bcs_pkg::TILE_BLOCKED};
    endfunction

    function bit is_bt(int i, int j);
      bit e, w, s;
      e = tile_at(i, j - 1) == bcs_pkg::TILE_FREE &&
          (closed(i + 1, j - 1) || closed(i - 1, j - 1));
      w = tile_at(i, j + 1) == bcs_pkg::TILE_FREE &&
          (closed(i + 1, j + 1) || closed(i - 1, j + 1));
      s = tile_at(i - 1, j) == bcs_pkg::TILE_FREE &&
          (closed(i - 1, j + 1) || closed(i - 1, j - 1));
      return e || w || s;
    endfunction

    function bit nearest_bt(int rr, int rc);
      bit found;
      int best, br, bc, d;
      found = 0;
      best = 0;
      br = 0;
      bc = 0;
      for (int i = 1; i < SIDE - 1; i++)
        for (int j = 1; j < SIDE - 1; j++)
          if (grid[i][j] == bcs_pkg::TILE_COVERED && is_bt(i, j)) begin
            d = (i - rr) * (i - rr) + (j - rc) * (j - rc);
            if (!found || d < best) begin
              found = 1;
              best = d;
              br = i;
              bc = j;
            end
          end
      if (found) begin
        goal_r = 7'(br);
        goal_c = 7'(bc);
      end
      return found;
    endfunction

    function void visit(int r, int c, bit fr, ref bit chosen);
      if (on_grid(r, c) && grid[r][c] == bcs_pkg::TILE_COVERED) return;
      if (!on_grid(r, c) || !fr) begin
        mark(r, c, bcs_pkg::TILE_BLOCKED);
        return;
      end
      if (!has_goal) begin
        goal_r = 7'(r);
        goal_c = 7'(c);
        has_goal = 1;
        chosen = 1;
      end else begin
        mark(r, c, bcs_pkg::TILE_FREE);
      end
    endfunction

    function void note_step(logic [6:0] r, logic [6:0] c, bit fn, bit fs, bit fe, bit fw);
      bit chosen;
      int ri, ci;
      goal_t g;
      chosen = 0;
      ri = int'(r);
      ci = int'(c);
      g.status = bcs_pkg::STAT_KEPT;
      if (goal_r == r && goal_c == c) begin
        has_goal = 0;
        mark(ri, ci, bcs_pkg::TILE_COVERED);
      end
      visit(ri + 1, ci, fn, chosen);
      visit(ri - 1, ci, fs, chosen);
      visit(ri, ci - 1, fe, chosen);
      visit(ri, ci + 1, fw, chosen);
      if (chosen) g.status = bcs_pkg::STAT_NEW_DIR;
      else if (!has_goal) begin
        g.status = nearest_bt(ri, ci) ? bcs_pkg::STAT_BACKTRACK : bcs_pkg::STAT_CRITICAL;
        has_goal = 1;
      end
      g.row = goal_r;
      g.col = goal_c;
      pending = {pending, g};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [6:0] r, logic [6:0] c, logic [1:0] st);
      goal_t g;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat goal (%0d,%0d) status %0d", r, c, st));
        return;
      end
      g = pending.pop_front();
      stat_cnt[g.status]++;
      if (r !== g.row) report($sformatf("goal_row %0d, want %0d", r, g.row));
      if (c !== g.col) report($sformatf("goal_col %0d, want %0d", c, g.col));
      if (st !== g.status) report($sformatf("step_status %0d, want %0d", st, g.status));
    endtask
  endclass

  logic clk;
  logic rst;
  int   phase;
  int   wdog;
  bcs_in_if  step_in ();
  bcs_out_if step_out ();
  coverage_scoreboard sb;

  boustrophedon_coverage_step i_dut (
    .clk      (clk),
    .rst      (rst),
    .step_in  (step_in.sink),
    .step_out (step_out.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function int tx_idle();
    return phase == 0 ? 37 : phase == 1 ? 73 : 0;
  endfunction

  function int rx_idle();
    return phase == 0 ? 73 : phase == 1 ? 37 : 0;
  endfunction

  always @(posedge clk) begin
    if (rst) step_out.ready <= 0;
    else step_out.ready <= $urandom_range(99) >= rx_idle();
  end

  always @(posedge clk) begin
    if (!rst && step_out.valid && step_out.ready)
      sb.check_result(step_out.goal_row, step_out.goal_col, step_out.step_status);
  end

  always @(posedge clk) begin
    if (rst || (step_in.valid && step_in.ready) || (step_out.valid && step_out.ready))
      wdog <= 0;
    else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("watchdog: no beat for %0d cycles", WDOG_MAX);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // one input beat, then at times a random gap
  task send_step(logic [6:0] r, logic [6:0] c, bit fn, bit fs, bit fe, bit fw);
    step_in.valid      <= 1;
    step_in.robot_row  <= r;
    step_in.robot_col  <= c;
    step_in.free_north <= fn;
    step_in.free_south <= fs;
    step_in.free_east  <= fe;
    step_in.free_west  <= fw;
    @(posedge clk);
    while (!step_in.ready) @(posedge clk);
    sb.note_step(r, c, fn, fs, fe, fw);
    if ($urandom_range(99) < tx_idle()) begin
      step_in.valid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task send_rand();
    logic [6:0] r, c;
    bit [3:0] fl;
    if ($urandom_range(99) < 80) begin
      r = sb.goal_r;
      c = sb.goal_c;
      for (int k = 0; k < 4; k++) fl[k] = $urandom_range(99) < 65;
    end else begin
      r = 7'($urandom);
      c = 7'($urandom);
      fl = 4'($urandom);
    end
    send_step(r, c, fl[0], fl[1], fl[2], fl[3]);
  endtask

  initial begin
    sb = new();
    phase = 0;
    rst = 1;
    step_in.valid      <= 0;
    step_in.robot_row  <= 0;
    step_in.robot_col  <= 0;
    step_in.free_north <= 0;
    step_in.free_south <= 0;
    step_in.free_east  <= 0;
    step_in.free_west  <= 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: corners, edges, goal walks, assorted flag patterns
    send_step(7'(ORIGIN), 7'(ORIGIN), 1'b1, 1'b1, 1'b1, 1'b1);
    send_step(sb.goal_r, sb.goal_c, 1'b0, 1'b0, 1'b0, 1'b0);
    send_step(sb.goal_r, sb.goal_c, 1'b1, 1'b0, 1'b1, 1'b0);
    send_step(7'd0, 7'd0, 1'b1, 1'b1, 1'b1, 1'b1);
    send_step(7'd127, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1);
    send_step(7'd0, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1);
    send_step(7'd127, 7'd0, 1'b0, 1'b1, 1'b0, 1'b1);
    send_step(sb.goal_r, sb.goal_c, 1'b0, 1'b0, 1'b0, 1'b0);
    send_step(sb.goal_r, sb.goal_c, 1'b0, 1'b1, 1'b0, 1'b0);
    send_step(sb.goal_r, sb.goal_c, 1'b0, 1'b0, 1'b1, 1'b0);
    send_step(sb.goal_r, sb.goal_c, 1'b0, 1'b0, 1'b0, 1'b1);
    send_step(sb.goal_r, sb.goal_c, 1'b1, 1'b1, 1'b1, 1'b1);
    send_step(sb.goal_r, sb.goal_c, 1'b0, 1'b0, 1'b0, 1'b0);
    send_step(7'd1, 7'd1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_step(7'd126, 7'd126, 1'b1, 1'b1, 1'b1, 1'b1);
    send_step(sb.goal_r, sb.goal_c, 1'b1, 1'b1, 1'b0, 1'b0);
    send_step(sb.goal_r, sb.goal_c, 1'b0, 1'b0, 1'b1, 1'b1);

    for (int n = 0; n < NUM_RAND; n++) begin
      phase = n * 3 / NUM_RAND;
      send_rand();
    end
    step_in.valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d steps: %0d kept, %0d new direction, %0d backtrack, %0d critical",
             NUM_RAND + 17, sb.stat_cnt[bcs_pkg::STAT_KEPT],
             sb.stat_cnt[bcs_pkg::STAT_NEW_DIR],
             sb.stat_cnt[bcs_pkg::STAT_BACKTRACK], sb.stat_cnt[bcs_pkg::STAT_CRITICAL]);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/bcs_pkg.sv
rtl/bcs_in_if.sv
rtl/bcs_out_if.sv
rtl/bcs_scan.sv
rtl/boustrophedon_coverage_step.sv
sim/boustrophedon_coverage_step_tb.sv
